### rtl/core/dtbo_pkg.sv
// ----------------------------------------------------------------------------
// dtbo_pkg
// Shared types and codes for the depth test and blend output unit: register
// map, item kinds, result codes and the control/status groups between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package dtbo_pkg;

	localparam int APB_AW  = 4;
	localparam int APB_DW  = 32;
	localparam int SIZE_W  = 9;
	localparam int COORD_W = 8;
	localparam int DEPTH_W = 24;
	localparam int CHAN_W  = 8;
	localparam int COLOR_W = 4 * CHAN_W;

	localparam logic [1:0] REG_Y_REVERSED    = 2'd0;
	localparam logic [1:0] REG_ACTIVE_WIDTH  = 2'd1;
	localparam logic [1:0] REG_ACTIVE_HEIGHT = 2'd2;

	localparam logic KIND_FRAGMENT = 1'b0;
	localparam logic KIND_CLEAR    = 1'b1;

	localparam logic [1:0] ST_REJECTED = 2'd0;
	localparam logic [1:0] ST_STORED   = 2'd1;
	localparam logic [1:0] ST_CLEARED  = 2'd2;
	localparam logic [1:0] ST_RANGE    = 2'd3;

	localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'd255;

	typedef struct packed {
		logic               y_reversed;
		logic [SIZE_W-1:0] active_width;
		logic [SIZE_W-1:0] active_height;
	} dtbo_cfg_t;

	typedef struct packed {
		logic capture;
		logic clear_init;
		logic lookup;
		logic blend;
		logic commit;
		logic clear_step;
	} dtbo_cmd_t;

	typedef struct packed {
		logic discard;
		logic out_range;
		logic pass;
		logic area_empty;
		logic clear_last;
	} dtbo_flags_t;

endpackage

`default_nettype wire

### rtl/core/dtbo_regs.sv
// ----------------------------------------------------------------------------
// dtbo_regs
// APB register file: row flip and active area size.
// ----------------------------------------------------------------------------
`default_nettype none

module dtbo_regs
	import dtbo_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready,
	output dtbo_cfg_t              cfg
);

	logic              y_reversed_q;
	logic [SIZE_W-1:0] active_width_q;
	logic [SIZE_W-1:0] active_height_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			y_reversed_q    <= 1'b0;
			active_width_q  <= SIZE_W'(256);
			active_height_q <= SIZE_W'(256);
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_Y_REVERSED:    y_reversed_q    <= pwdata[0];
				REG_ACTIVE_WIDTH:  active_width_q  <= pwdata[SIZE_W-1:0];
				REG_ACTIVE_HEIGHT: active_height_q <= pwdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_Y_REVERSED:    prdata = APB_DW'(y_reversed_q);
			REG_ACTIVE_WIDTH:  prdata = APB_DW'(active_width_q);
			REG_ACTIVE_HEIGHT: prdata = APB_DW'(active_height_q);
			default:           prdata = '0;
		endcase
	end

	assign cfg.y_reversed    = y_reversed_q;
	assign cfg.active_width  = active_width_q;
	assign cfg.active_height = active_height_q;

endmodule

`default_nettype wire

### rtl/core/dtbo_ctrl.sv
// ----------------------------------------------------------------------------
// dtbo_ctrl
// Sequencer: fragment lookup, blend and commit, clear sweep, result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module dtbo_ctrl
	import dtbo_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        kind,
	input  dtbo_flags_t      flags,
	output dtbo_cmd_t        cmd,
	output logic             busy,
	output logic             done,
	output logic [1:0]       status
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_LOOKUP = 5'b00010,
		S_BLEND  = 5'b00100,
		S_COMMIT = 5'b01000,
		S_CLEAR  = 5'b10000
	} state_t;

	state_t     state_q, state_nxt;
	logic       report;
	logic [1:0] code;
	logic       done_q;
	logic [1:0] status_q;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		report    = 1'b0;
		code      = ST_REJECTED;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					if (kind == KIND_CLEAR) begin
						cmd.clear_init = 1'b1;
						state_nxt      = S_CLEAR;
					end else begin
						state_nxt = S_LOOKUP;
					end
				end
			end
			S_LOOKUP: begin
				if (flags.discard) begin
					report    = 1'b1;
					code      = ST_REJECTED;
					state_nxt = S_IDLE;
				end else if (flags.out_range) begin
					report    = 1'b1;
					code      = ST_RANGE;
					state_nxt = S_IDLE;
				end else begin
					cmd.lookup = 1'b1;
					state_nxt  = S_BLEND;
				end
			end
			S_BLEND: begin
				cmd.blend = 1'b1;
				state_nxt = S_COMMIT;
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				report     = 1'b1;
				code       = flags.pass ? ST_STORED : ST_REJECTED;
				state_nxt  = S_IDLE;
			end
			S_CLEAR: begin
				if (flags.area_empty) begin
					report    = 1'b1;
					code      = ST_CLEARED;
					state_nxt = S_IDLE;
				end else begin
					cmd.clear_step = 1'b1;
					if (flags.clear_last) begin
						report    = 1'b1;
						code      = ST_CLEARED;
						state_nxt = S_IDLE;
					end
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= report;
		end
	end

	always_ff @(posedge clk) begin
		if (report) begin
			status_q <= code;
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign status = status_q;

endmodule

`default_nettype wire

### rtl/core/dtbo_dp.sv
// ----------------------------------------------------------------------------
// dtbo_dp
// Datapath: word capture, range check and row flip, depth and colour stores,
// depth compare, alpha blend and clear address counters.
// ----------------------------------------------------------------------------
`default_nettype none

module dtbo_dp
	import dtbo_pkg::*;
#(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  dtbo_cfg_t               cfg,
	input  dtbo_cmd_t               cmd,
	input  wire logic [COORD_W-1:0] pixel_x,
	input  wire logic [COORD_W-1:0] pixel_y,
	input  wire logic [DEPTH_W-1:0] frag_depth,
	input  wire logic [CHAN_W-1:0]  red,
	input  wire logic [CHAN_W-1:0]  green,
	input  wire logic [CHAN_W-1:0]  blue,
	input  wire logic [CHAN_W-1:0]  alpha,
	input  wire logic               discard_flag,
	input  wire logic               clear_color_enable,
	input  wire logic               clear_depth_enable,
	output dtbo_flags_t             flags
);

	localparam int MAXD    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int CW      = ($clog2(MAXD + 1) > SIZE_W) ? $clog2(MAXD + 1) : SIZE_W;
	localparam int XW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int YW      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int AW      = XW + YW;
	localparam int MEM_DEP = 1 << AW;
	localparam int SUM_W   = 2 * CHAN_W;

	function automatic logic [CHAN_W-1:0] div255(input logic [SUM_W-1:0] v);
		logic [SUM_W:0] t;
		t = (SUM_W+1)'(v) + (SUM_W+1)'(1) + (SUM_W+1)'(v >> CHAN_W);
		return t[SUM_W-1:CHAN_W];
	endfunction

	logic [COORD_W-1:0] pixel_x_q, pixel_y_q;
	logic [DEPTH_W-1:0] frag_depth_q;
	logic [CHAN_W-1:0]  red_q, green_q, blue_q, alpha_q;
	logic               discard_q, cce_q, cde_q;

	logic [DEPTH_W-1:0] depth_mem [MEM_DEP];
	logic [COLOR_W-1:0] color_mem [MEM_DEP];
	logic [DEPTH_W-1:0] depth_rd_q;
	logic [COLOR_W-1:0] color_rd_q;

	logic               pass_q;
	logic [SUM_W-1:0]   sum_r_q, sum_g_q, sum_b_q;
	logic [CW-1:0]      ccol_q, crow_q;

	logic [CW-1:0]      aw_ext, ah_ext, eff_w, eff_h, px_ext, py_ext, row;
	logic [AW-1:0]      frag_addr, clear_addr, wr_addr;
	logic [CHAN_W-1:0]  inv_a;
	logic               last_col, last_row;
	logic               depth_we, color_we;
	logic [COLOR_W-1:0] frag_color, blend_color, color_wd;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pixel_x_q    <= pixel_x;
			pixel_y_q    <= pixel_y;
			frag_depth_q <= frag_depth;
			red_q        <= red;
			green_q      <= green;
			blue_q       <= blue;
			alpha_q      <= alpha;
			discard_q    <= discard_flag;
			cce_q        <= clear_color_enable;
			cde_q        <= clear_depth_enable;
		end
	end

	assign aw_ext = CW'(cfg.active_width);
	assign ah_ext = CW'(cfg.active_height);
	assign eff_w  = (aw_ext > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : aw_ext;
	assign eff_h  = (ah_ext > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : ah_ext;
	assign px_ext = CW'(pixel_x_q);
	assign py_ext = CW'(pixel_y_q);
	assign row    = cfg.y_reversed ? (eff_h - py_ext - CW'(1)) : py_ext;

	assign frag_addr  = {row[YW-1:0], px_ext[XW-1:0]};
	assign clear_addr = {crow_q[YW-1:0], ccol_q[XW-1:0]};
	assign wr_addr    = cmd.clear_step ? clear_addr : frag_addr;

	assign last_col = (ccol_q == eff_w - CW'(1));
	assign last_row = (crow_q == eff_h - CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ccol_q <= '0;
			crow_q <= '0;
		end else if (cmd.clear_init) begin
			ccol_q <= '0;
			crow_q <= '0;
		end else if (cmd.clear_step) begin
			if (last_col) begin
				ccol_q <= '0;
				crow_q <= crow_q + CW'(1);
			end else begin
				ccol_q <= ccol_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			depth_rd_q <= depth_mem[frag_addr];
			color_rd_q <= color_mem[frag_addr];
		end
	end

	assign inv_a = ALPHA_OPAQUE - alpha_q;

	always_ff @(posedge clk) begin
		if (cmd.blend) begin
			pass_q  <= (frag_depth_q < depth_rd_q);
			sum_r_q <= SUM_W'(red_q) * SUM_W'(alpha_q)
				+ SUM_W'(color_rd_q[7:0]) * SUM_W'(inv_a);
			sum_g_q <= SUM_W'(green_q) * SUM_W'(alpha_q)
				+ SUM_W'(color_rd_q[15:8]) * SUM_W'(inv_a);
			sum_b_q <= SUM_W'(blue_q) * SUM_W'(alpha_q)
				+ SUM_W'(color_rd_q[23:16]) * SUM_W'(inv_a);
		end
	end

	assign frag_color  = {alpha_q, blue_q, green_q, red_q};
	assign blend_color = {color_rd_q[31:24], div255(sum_b_q), div255(sum_g_q),
		div255(sum_r_q)};

	always_comb begin
		if (cmd.clear_step) begin
			color_wd = frag_color;
		end else if (alpha_q == ALPHA_OPAQUE) begin
			color_wd = frag_color;
		end else begin
			color_wd = blend_color;
		end
	end

	assign depth_we = (cmd.commit & pass_q) | (cmd.clear_step & cde_q);
	assign color_we = (cmd.commit & pass_q) | (cmd.clear_step & cce_q);

	always_ff @(posedge clk) begin
		if (depth_we) begin
			depth_mem[wr_addr] <= frag_depth_q;
		end
	end

	always_ff @(posedge clk) begin
		if (color_we) begin
			color_mem[wr_addr] <= color_wd;
		end
	end

	assign flags.discard    = discard_q;
	assign flags.out_range  = (px_ext >= eff_w) || (py_ext >= eff_h);
	assign flags.pass       = pass_q;
	assign flags.area_empty = (eff_w == '0) || (eff_h == '0);
	assign flags.clear_last = last_col & last_row;

endmodule

`default_nettype wire

### rtl/core/depth_test_blend_output_unit.sv
// ----------------------------------------------------------------------------
// depth_test_blend_output_unit
// Render output stage: depth test and alpha blend into on-chip depth and
// RGBA8 colour stores, with a clear sweep over the active area.
//
//   channel   ports                                    direction  handshake
//   config    psel penable pwrite paddr pwdata prdata  in/out     APB, pready=1
//   item      start kind pixel_x .. clear_depth_enable in         start & !busy
//   result    done status                              out        done strobe
//
// A fragment runs store read, compare and blend, then write back; it ends
// early, with no store read, when discarded or out of range. A clear writes
// one entry per cycle over the active area, and none over an empty area. The
// result word shows for one cycle after the item completes and cannot be held
// off; a new word may be accepted in that cycle. Reset returns to idle; the
// stores hold nothing defined until cleared or drawn.
// ----------------------------------------------------------------------------
`default_nettype none

module depth_test_blend_output_unit
	import dtbo_pkg::*;
#(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [APB_AW-1:0]  paddr,
	input  wire logic [APB_DW-1:0]  pwdata,
	output logic      [APB_DW-1:0]  prdata,
	output logic                    pready,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               kind,
	input  wire logic [COORD_W-1:0] pixel_x,
	input  wire logic [COORD_W-1:0] pixel_y,
	input  wire logic [DEPTH_W-1:0] frag_depth,
	input  wire logic [CHAN_W-1:0]  red,
	input  wire logic [CHAN_W-1:0]  green,
	input  wire logic [CHAN_W-1:0]  blue,
	input  wire logic [CHAN_W-1:0]  alpha,
	input  wire logic               discard_flag,
	input  wire logic               clear_color_enable,
	input  wire logic               clear_depth_enable,
	output logic                    done,
	output logic [1:0]              status
);

	dtbo_cfg_t   cfg;
	dtbo_cmd_t   cmd;
	dtbo_flags_t flags;

	dtbo_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dtbo_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.flags  (flags),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.status (status)
	);

	dtbo_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg                (cfg),
		.cmd                (cmd),
		.pixel_x            (pixel_x),
		.pixel_y            (pixel_y),
		.frag_depth         (frag_depth),
		.red                (red),
		.green              (green),
		.blue               (blue),
		.alpha              (alpha),
		.discard_flag       (discard_flag),
		.clear_color_enable (clear_color_enable),
		.clear_depth_enable (clear_depth_enable),
		.flags              (flags)
	);

endmodule

`default_nettype wire
